FILE: src/sort_dedup_median_core_assert.svh
// assertion macros for the sort, dedup and median core
`ifndef SORT_DEDUP_MEDIAN_CORE_ASSERT_SVH
`define SORT_DEDUP_MEDIAN_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SDM_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sdm assertion failed");
`define SDM_ASSERT_NEVER(label, clk, rstn, expr) \
    `SDM_ASSERT(label, clk, rstn, !(expr))
`else
`define SDM_ASSERT(label, clk, rstn, prop)
`define SDM_ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

FILE: src/sdm_pkg.sv
// shared constants for the sort, dedup and median core
package sdm_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 16;

endpackage

FILE: src/sdm_cell.sv
// one cell of the insertion chain: holds one distinct value, passes larger ones on
module sdm_cell #(
    parameter int DATA_WIDTH = sdm_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         shift_en,
    input  logic                         in_v,
    input  logic signed [DATA_WIDTH-1:0] in_d,
    input  logic                         nbr_v,
    input  logic signed [DATA_WIDTH-1:0] nbr_d,
    output logic                         held_v,
    output logic signed [DATA_WIDTH-1:0] held_d,
    output logic                         out_v,
    output logic signed [DATA_WIDTH-1:0] out_d,
    output logic                         fill
);

    logic                         held_v_reg, held_v_next;
    logic signed [DATA_WIDTH-1:0] held_d_reg, held_d_next;
    logic                         out_v_reg, out_v_next;
    logic signed [DATA_WIDTH-1:0] out_d_reg, out_d_next;

    always_comb begin
        held_v_next = held_v_reg;
        held_d_next = held_d_reg;
        out_v_next  = 1'b0;
        out_d_next  = in_d;
        if (shift_en) begin
            held_v_next = nbr_v;
            held_d_next = nbr_d;
        end else if (in_v) begin
            if (!held_v_reg) begin
                held_v_next = 1'b1;
                held_d_next = in_d;
            end else if (in_d < held_d_reg) begin
                held_d_next = in_d;
                out_v_next  = 1'b1;
                out_d_next  = held_d_reg;
            end else if (in_d != held_d_reg) begin
                out_v_next = 1'b1;
            end
        end
    end

    assign fill = in_v && !held_v_reg && !shift_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            held_v_reg <= held_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_d_reg <= held_d_next;
        out_d_reg  <= out_d_next;
    end

    assign held_v = held_v_reg;
    assign held_d = held_d_reg;
    assign out_v  = out_v_reg;
    assign out_d  = out_d_reg;

endmodule

FILE: src/sort_dedup_median_core.sv
// top level of the sort, dedup and median core
// Values of a batch enter one per cycle through the slave stream, but only while
// the core is loading; tlast closes the batch. Each value travels down a chain of
// DEPTH cells, one cell per cycle, and settles in ascending order, duplicates being
// dropped on the way; values beyond DEPTH per batch are dropped and flagged as
// overflow. After the closing transfer the chain settles, then shifts out one
// distinct value per cycle on the master stream while the consumer keeps tready
// high, the final one carrying count, median, min, max and overflow. The input is
// held off from the closing transfer until the final value is shifted out; a
// finished result may wait in the output register while the next batch loads.
module sort_dedup_median_core #(
    parameter  int DEPTH      = sdm_pkg::DEPTH_DEF,
    parameter  int DATA_WIDTH = sdm_pkg::DATA_WIDTH_DEF,
    localparam int POS_W      = $clog2(DEPTH),
    localparam int CNT_W      = $clog2(DEPTH + 1),
    localparam int S_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int M_RAW_W    = 5 * DATA_WIDTH + POS_W + CNT_W + 1,
    localparam int M_TDATA_W  = ((M_RAW_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // value
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // sorted_value, position, unique_count, median_low, median_high,
    // min_value, max_value, overflow
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser    // median_is_pair
);

    `include "sort_dedup_median_core_assert.svh"

    typedef enum logic [1:0] {ST_LOAD, ST_DRAIN, ST_EMIT} state_t;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             fill_reg, fill_next;
    logic [CNT_W-1:0]             uniq_reg, uniq_next;
    logic [CNT_W-1:0]             drain_reg, drain_next;
    logic [POS_W-1:0]             idx_reg, idx_next;
    logic                         ovf_reg, ovf_next;
    logic                         inj_v_reg, inj_v_next;
    logic signed [DATA_WIDTH-1:0] inj_d_reg;
    logic signed [DATA_WIDTH-1:0] lo_reg, lo_next;
    logic signed [DATA_WIDTH-1:0] hi_reg, hi_next;
    logic signed [DATA_WIDTH-1:0] min_reg, min_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic                         m_tlast_reg, m_tlast_next;
    logic                         m_pair_reg, m_pair_next;
    logic signed [DATA_WIDTH-1:0] m_val_reg, m_val_next;
    logic [POS_W-1:0]             m_pos_reg, m_pos_next;
    logic [CNT_W-1:0]             m_cnt_reg, m_cnt_next;
    logic signed [DATA_WIDTH-1:0] m_lo_reg, m_lo_next;
    logic signed [DATA_WIDTH-1:0] m_hi_reg, m_hi_next;
    logic signed [DATA_WIDTH-1:0] m_min_reg, m_min_next;
    logic signed [DATA_WIDTH-1:0] m_max_reg, m_max_next;
    logic                         m_ovf_reg, m_ovf_next;

    logic [DEPTH:0]               tok_v;
    logic signed [DATA_WIDTH-1:0] tok_d [DEPTH+1];
    logic [DEPTH-1:0]             held_v;
    logic signed [DATA_WIDTH-1:0] held_d [DEPTH];
    logic [DEPTH-1:0]             fill_vec;

    logic                         s_accept;
    logic                         emit_go;
    logic                         is_final;
    logic [CNT_W-1:0]             lo_idx;
    logic [CNT_W-1:0]             hi_idx;
    logic signed [DATA_WIDTH-1:0] cur;
    logic signed [DATA_WIDTH-1:0] lo_val;
    logic signed [DATA_WIDTH-1:0] hi_val;
    logic signed [DATA_WIDTH-1:0] min_val;

    assign tok_v[0] = inj_v_reg;
    assign tok_d[0] = inj_d_reg;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic                         nbr_v;
        logic signed [DATA_WIDTH-1:0] nbr_d;
        if (k < DEPTH - 1) begin : g_mid
            assign nbr_v = held_v[k+1];
            assign nbr_d = held_d[k+1];
        end else begin : g_end
            assign nbr_v = 1'b0;
            assign nbr_d = '0;
        end
        sdm_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (emit_go),
            .in_v     (tok_v[k]),
            .in_d     (tok_d[k]),
            .nbr_v    (nbr_v),
            .nbr_d    (nbr_d),
            .held_v   (held_v[k]),
            .held_d   (held_d[k]),
            .out_v    (tok_v[k+1]),
            .out_d    (tok_d[k+1]),
            .fill     (fill_vec[k])
        );
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign emit_go  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
    assign cur      = held_d[0];
    assign is_final = (CNT_W'(idx_reg) + CNT_W'(1)) == uniq_reg;
    assign lo_idx   = (uniq_reg - CNT_W'(1)) >> 1;
    assign hi_idx   = uniq_reg >> 1;
    assign lo_val   = (CNT_W'(idx_reg) == lo_idx) ? cur : lo_reg;
    assign hi_val   = (CNT_W'(idx_reg) == hi_idx) ? cur : hi_reg;
    assign min_val  = (idx_reg == '0) ? cur : min_reg;

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        uniq_next     = uniq_reg;
        drain_next    = drain_reg;
        idx_next      = idx_reg;
        ovf_next      = ovf_reg;
        inj_v_next    = s_accept && (fill_reg < DEPTH_C);
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        min_next      = min_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tlast_next  = m_tlast_reg;
        m_pair_next   = m_pair_reg;
        m_val_next    = m_val_reg;
        m_pos_next    = m_pos_reg;
        m_cnt_next    = m_cnt_reg;
        m_lo_next     = m_lo_reg;
        m_hi_next     = m_hi_reg;
        m_min_next    = m_min_reg;
        m_max_next    = m_max_reg;
        m_ovf_next    = m_ovf_reg;

        if (|fill_vec) begin
            uniq_next = uniq_reg + CNT_W'(1);
        end
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (fill_reg < DEPTH_C) begin
                        fill_next = fill_reg + CNT_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_DRAIN;
                        drain_next = DEPTH_C;
                    end
                end
            end
            ST_DRAIN: begin
                if (drain_reg == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    drain_next = drain_reg - CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    m_tvalid_next = 1'b1;
                    m_val_next    = cur;
                    m_pos_next    = idx_reg;
                    m_tlast_next  = is_final;
                    m_cnt_next    = is_final ? uniq_reg : '0;
                    m_lo_next     = is_final ? lo_val : '0;
                    m_hi_next     = is_final ? hi_val : '0;
                    m_pair_next   = is_final && !uniq_reg[0];
                    m_min_next    = is_final ? min_val : '0;
                    m_max_next    = is_final ? cur : '0;
                    m_ovf_next    = is_final && ovf_reg;
                    lo_next       = lo_val;
                    hi_next       = hi_val;
                    min_next      = min_val;
                    idx_next      = idx_reg + POS_W'(1);
                    if (is_final) begin
                        state_next = ST_LOAD;
                        fill_next  = '0;
                        uniq_next  = '0;
                        ovf_next   = 1'b0;
                        idx_next   = '0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            fill_reg     <= '0;
            uniq_reg     <= '0;
            drain_reg    <= '0;
            idx_reg      <= '0;
            ovf_reg      <= 1'b0;
            inj_v_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            uniq_reg     <= uniq_next;
            drain_reg    <= drain_next;
            idx_reg      <= idx_next;
            ovf_reg      <= ovf_next;
            inj_v_reg    <= inj_v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        inj_d_reg   <= s_tdata[DATA_WIDTH-1:0];
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        min_reg     <= min_next;
        m_tlast_reg <= m_tlast_next;
        m_pair_reg  <= m_pair_next;
        m_val_reg   <= m_val_next;
        m_pos_reg   <= m_pos_next;
        m_cnt_reg   <= m_cnt_next;
        m_lo_reg    <= m_lo_next;
        m_hi_reg    <= m_hi_next;
        m_min_reg   <= m_min_next;
        m_max_reg   <= m_max_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_pair_reg;
    assign m_tdata  = M_TDATA_W'({m_ovf_reg, m_max_reg, m_min_reg, m_hi_reg, m_lo_reg,
                                  m_cnt_reg, m_pos_reg, m_val_reg});

    // a value never runs off the end of the chain
    `SDM_ASSERT_NEVER(a_tok_lost, aclk, aresetn, tok_v[DEPTH])
    `SDM_ASSERT(a_one_fill, aclk, aresetn, $onehot0(fill_vec))
    `SDM_ASSERT(a_settled_emit, aclk, aresetn, (state_reg == ST_EMIT) |-> (tok_v == '0))
    `SDM_ASSERT(a_uniq_le_fill, aclk, aresetn, uniq_reg <= fill_reg)
    `SDM_ASSERT(a_last_count, aclk, aresetn,
        (m_tvalid_reg && m_tlast_reg) |-> (m_cnt_reg == (CNT_W'(m_pos_reg) + CNT_W'(1))))

endmodule
